@@ design/multilevel_feedback_queue_top_assert.svh @@
// Assertion macros shared by the ready queue RTL
`ifndef MULTILEVEL_FEEDBACK_QUEUE_TOP_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define MFQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define MFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/mfq_pkg.sv @@
`timescale 1ns / 1ps

package mfq_pkg;

    // Default sizing
    localparam int NUM_LEVELS_DEF  = 8;
    localparam int LEVEL_DEPTH_DEF = 16;
    localparam int ID_WIDTH_DEF    = 16;

    // Field widths on the streams
    localparam int PID_W    = 16;
    localparam int PRIO_W   = 3;
    localparam int STATUS_W = 3;
    localparam int LIU_W    = 4;
    localparam int TDATA_W  = 24;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_LEVELS_IN_USE = 1'b0;  // register index, taken from paddr[2]
    localparam logic [LIU_W-1:0] LIU_RESET = 4'd8;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_FETCH  = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FETCHED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd4;

    // One result transaction
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PID_W-1:0]    pid;
        logic [PRIO_W-1:0]   level;
        logic                flag;
    } t_result;

endpackage

@@ design/multilevel_feedback_queue_top.sv @@
`timescale 1ns / 1ps
// Multi-level feedback ready queue.
// Input stream (s_axis_*): one command per transaction. tuser is the operation
// (0 insert, 1 fetch); tdata carries process id, priority level and the
// used-whole-quantum flag. Output stream (m_axis_*): one result per command,
// tuser is the status, tdata the fetched id, level and stored quantum flag.
// The APB port holds levels_in_use at address 0; write it only while idle.
// An insert steps through accept (IDLE) and then EXEC, which does the pointer
// lookup and the store write; a fetch that finds an entry also passes through
// READ, since the entry comes out of the registered store RAM read port after
// the head pointer is read in EXEC. One command is worked on at a time. The
// result register is loaded from EXEC for an insert or an empty fetch, and
// from READ for a fetch that returns an entry.
// A result register sits on the output; while it is stalled by m_axis_tready
// the block holds the next command's work until the slot frees up.
// Reset clears all pointers and counts at once (every level empty) and sets
// levels_in_use to 8; store RAM contents are not cleared and need no pass.
module multilevel_feedback_queue_top #(
    parameter int NUM_LEVELS  = mfq_pkg::NUM_LEVELS_DEF,
    parameter int LEVEL_DEPTH = mfq_pkg::LEVEL_DEPTH_DEF,
    parameter int ID_WIDTH    = mfq_pkg::ID_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Command stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [15:0] process_id, [18:16] priority_req, [19] finished_quantum, [23:20] zero
    input  logic [mfq_pkg::TDATA_W-1:0]       s_axis_tdata,
    // [0] operation
    input  logic                              s_axis_tuser,
    // Result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [15:0] process_id_res, [18:16] level, [19] finished_quantum_res, [23:20] zero
    output logic [mfq_pkg::TDATA_W-1:0]       m_axis_tdata,
    // [2:0] status
    output logic [mfq_pkg::STATUS_W-1:0]      m_axis_tuser,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mfq_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [mfq_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [mfq_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);

    `include "multilevel_feedback_queue_top_assert.svh"

    localparam int LW    = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int PW    = $clog2(LEVEL_DEPTH);
    localparam int CW    = $clog2(LEVEL_DEPTH + 1);
    localparam int MEM_D = NUM_LEVELS * LEVEL_DEPTH;
    localparam int AW    = $clog2(MEM_D);
    localparam int WW    = ID_WIDTH + 1;
    localparam int EW    = 5;
    localparam logic [PW-1:0] LAST_SLOT = PW'(LEVEL_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(LEVEL_DEPTH);
    localparam logic [EW-1:0] NL        = EW'(NUM_LEVELS);

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0]                  r_state, n_state;
    logic                        r_op;
    logic [mfq_pkg::PID_W-1:0]   r_id;
    logic [mfq_pkg::PRIO_W-1:0]  r_prio;
    logic                        r_flag;
    logic [LW-1:0]               r_lvl, n_lvl;
    logic [mfq_pkg::LIU_W-1:0]   r_liu;

    logic [PW-1:0] r_head  [NUM_LEVELS];
    logic [PW-1:0] r_tail  [NUM_LEVELS];
    logic [CW-1:0] r_count [NUM_LEVELS];
    logic [PW-1:0] n_head  [NUM_LEVELS];
    logic [PW-1:0] n_tail  [NUM_LEVELS];
    logic [CW-1:0] n_count [NUM_LEVELS];

    mfq_pkg::t_result r_out, n_out;
    logic             r_out_valid, n_out_valid;

    logic              s_accept, cfg_wr, out_free;
    logic [EW-1:0]     liu_ext, eff, lvl_base, lvl_ins;
    logic              demote, oor, any_ne, full;
    logic [LW-1:0]     fetch_idx, ins_idx, idx;
    logic [PW-1:0]     ptr;
    logic [AW-1:0]     addr;
    logic              ram_we, ram_re;
    logic [WW-1:0]     wdata, rdata;
    logic [31:0]       id_ext, rd_id_ext;

    assign pready        = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign cfg_wr        = psel && penable && pwrite && pready
                           && (paddr[2] == mfq_pkg::REG_LEVELS_IN_USE);
    assign out_free      = !r_out_valid || m_axis_tready;

    // Register read back
    always_comb begin
        prdata = '0;
        if (paddr[2] == mfq_pkg::REG_LEVELS_IN_USE) begin
            prdata = mfq_pkg::CFG_DATA_W'(r_liu);
        end
    end

    // Insert level: demotion and range check against the effective level count
    always_comb begin
        liu_ext  = EW'(r_liu);
        eff      = (liu_ext < NL) ? liu_ext : NL;
        lvl_base = EW'(r_prio);
        demote   = r_flag && ((lvl_base + EW'(1)) < eff);
        lvl_ins  = lvl_base + EW'(demote);
        oor      = (lvl_ins >= eff);
        ins_idx  = lvl_ins[LW-1:0];
    end

    // Fetch level: lowest-numbered nonempty level
    always_comb begin
        any_ne    = 1'b0;
        fetch_idx = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (r_count[i] != '0) begin
                any_ne    = 1'b1;
                fetch_idx = LW'(i);
            end
        end
    end

    assign idx  = (r_op == mfq_pkg::OP_FETCH) ? fetch_idx : ins_idx;
    assign full = (r_count[idx] == FULL_CNT);
    assign ptr  = (r_op == mfq_pkg::OP_FETCH) ? r_head[idx] : r_tail[idx];
    assign addr = AW'(idx) * AW'(LEVEL_DEPTH) + AW'(ptr);

    // Stored word: flag above the id
    assign id_ext    = 32'(r_id);
    assign wdata     = {r_flag, id_ext[ID_WIDTH-1:0]};
    assign rd_id_ext = 32'(rdata[ID_WIDTH-1:0]);

    // Sequencer and pointer update
    always_comb begin
        n_state     = r_state;
        n_lvl       = r_lvl;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_out       = r_out;
        n_out_valid = r_out_valid && !m_axis_tready;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                    if (r_op == mfq_pkg::OP_INSERT) begin
                        n_out_valid  = 1'b1;
                        n_out.pid    = '0;
                        n_out.flag   = 1'b0;
                        n_out.level  = lvl_ins[mfq_pkg::PRIO_W-1:0];
                        if (oor) begin
                            n_out.status = mfq_pkg::ST_RANGE;
                        end else if (full) begin
                            n_out.status = mfq_pkg::ST_FULL;
                        end else begin
                            n_out.status = mfq_pkg::ST_INSERTED;
                            ram_we       = 1'b1;
                            n_tail[idx]  = (ptr == LAST_SLOT) ? '0 : ptr + PW'(1);
                            n_count[idx] = r_count[idx] + CW'(1);
                        end
                    end else if (!any_ne) begin
                        n_out_valid  = 1'b1;
                        n_out.status = mfq_pkg::ST_EMPTY;
                        n_out.pid    = '0;
                        n_out.level  = '0;
                        n_out.flag   = 1'b0;
                    end else begin
                        ram_re       = 1'b1;
                        n_lvl        = idx;
                        n_head[idx]  = (ptr == LAST_SLOT) ? '0 : ptr + PW'(1);
                        n_count[idx] = r_count[idx] - CW'(1);
                        n_state      = S_READ;
                    end
                end
            end
            S_READ: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out.status = mfq_pkg::ST_FETCHED;
                    n_out.pid    = rd_id_ext[mfq_pkg::PID_W-1:0];
                    n_out.level  = mfq_pkg::PRIO_W'(r_lvl);
                    n_out.flag   = rdata[ID_WIDTH];
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_liu       <= mfq_pkg::LIU_RESET;
            for (int i = 0; i < NUM_LEVELS; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            if (cfg_wr) begin
                r_liu <= pwdata[mfq_pkg::LIU_W-1:0];
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_op   <= s_axis_tuser;
            r_id   <= s_axis_tdata[15:0];
            r_prio <= s_axis_tdata[18:16];
            r_flag <= s_axis_tdata[19];
        end
        r_lvl <= n_lvl;
        r_out <= n_out;
    end

    // Entry store, all levels side by side
    mfq_ram #(
        .WIDTH (WW),
        .DEPTH (MEM_D)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (addr),
        .i_wdata (wdata),
        .i_re    (ram_re),
        .i_raddr (addr),
        .o_rdata (rdata)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {4'b0, r_out.flag, r_out.level, r_out.pid};

    // Checks
    `MFQ_ASSERT_NOW(a_no_write_full, i_clk, i_rst_n, ram_we,
        (r_count[idx] < FULL_CNT), "store written into a full level")
    `MFQ_ASSERT_NOW(a_fetch_nonempty, i_clk, i_rst_n, ram_re,
        (r_count[idx] != '0), "fetch read from an empty level")
    `MFQ_ASSERT_NEXT(a_insert_fills, i_clk, i_rst_n, ram_we,
        (r_count[$past(idx)] != '0), "level still empty after insert")
    `MFQ_ASSERT_NEXT(a_read_result, i_clk, i_rst_n, (r_state == S_READ) && out_free,
        (m_axis_tvalid && (m_axis_tuser == mfq_pkg::ST_FETCHED)),
        "fetch read did not produce a fetched result")

endmodule

@@ design/mfq_ram.sv @@
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read port
module mfq_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
